### src/bmt_pkg.sv
// ----------------------------------------------------------------------------
// bmt_pkg: shared types and codes for the bounded multiset table
// Beat layouts for both channels, operation codes and the command
// bundle that the sequencer sends to every storage cell.
// ----------------------------------------------------------------------------
package bmt_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] value;
    } t_bmt_in;

    typedef struct packed {
        logic       ok;
        logic [4:0] match_count;
        logic       found;
        logic [4:0] size;
    } t_bmt_out;

    // Commit strobes, high for one cycle at the end of an operation
    typedef struct packed {
        logic add_en;
        logic rm_en;
    } t_bmt_cmd;

endpackage

### src/bmt_cell.sv
// ----------------------------------------------------------------------------
// bmt_cell: one slot of the bounded multiset table
// Holds one entry. A scan token passes through the row one cell a cycle,
// carrying the running match count and the first-match flag. At commit
// the cell takes the new value (add) or its neighbour's entry (remove).
// ----------------------------------------------------------------------------
module bmt_cell #(
    parameter int IDX         = 0,
    parameter int VALUE_WIDTH = 32,
    parameter int CW          = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_val,
    input  logic [CW-1:0]          i_fill,
    input  bmt_pkg::t_bmt_cmd      i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_next,
    input  logic                   i_tok,
    input  logic [CW-1:0]          i_cnt,
    input  logic                   i_have,
    output logic                   o_tok,
    output logic [CW-1:0]          o_cnt,
    output logic                   o_have,
    output logic [VALUE_WIDTH-1:0] o_entry
);

    logic                   r_tok;
    logic [CW-1:0]          r_cnt;
    logic                   r_have;
    logic [VALUE_WIDTH-1:0] r_entry;
    logic                   w_occupied;
    logic                   w_hit;
    logic                   w_is_tail;

    assign w_occupied = CW'(IDX) < i_fill;
    assign w_hit      = w_occupied && (r_entry == i_val);
    assign w_is_tail  = CW'(IDX) == i_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    // r_have doubles as "at or past the first match": such cells shift on remove
    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_cnt  <= i_cnt + CW'(w_hit);
            r_have <= i_have || w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_en && w_is_tail) begin
            r_entry <= i_val;
        end else if (i_cmd.rm_en && r_have) begin
            r_entry <= i_next;
        end
    end

    assign o_tok   = r_tok;
    assign o_cnt   = r_cnt;
    assign o_have  = r_have;
    assign o_entry = r_entry;

endmodule

### src/bounded_multiset_table.sv
// ----------------------------------------------------------------------------
// bounded_multiset_table: bounded bag of values kept in insertion order
// Input beat: func (add, remove first match, clear, query) and value.
// Output beat: ok, match_count and found (before the operation), size after.
//
// Storage is a row of DEPTH cells. After a beat is taken a scan token walks
// the row one cell per cycle, counting matches and marking the first one;
// a commit cycle then appends, closes the gap, empties the table or, for a query, leaves it as it is.
// The result beat passes r_start, the token walk over the cell row, the
// capture of count and flag and the commit into the output register; the
// next input beat can be taken once the result appears, so the block
// works on one item at a time.
// Input stall is high from acceptance until the commit cycle. The result
// sits in an output register: while the receiver stalls it holds, the block
// still takes the next input beat, and that beat's commit waits until the
// register is free.
// Reset (synchronous, active low) empties the table and drops any result
// beat not yet taken; stored entries are not cleared.
// ----------------------------------------------------------------------------
module bounded_multiset_table #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bmt_pkg::t_bmt_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bmt_pkg::t_bmt_out o_out
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [CW-1:0]          r_fill;
    logic [CW-1:0]          n_fill;
    logic                   r_start;
    logic [1:0]             r_op;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [CW-1:0]          r_cnt;
    logic                   r_have;
    logic                   r_out_valid;
    bmt_pkg::t_bmt_out      r_out;

    logic                   w_tok  [0:DEPTH];
    logic [CW-1:0]          w_cnt  [0:DEPTH];
    logic                   w_have [0:DEPTH];
    logic [VALUE_WIDTH-1:0] w_entry[0:DEPTH-1];

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_commit;
    logic                   w_full;
    logic                   w_ok;
    bmt_pkg::t_bmt_cmd      w_cmd;

    function automatic logic [4:0] to_5(input logic [CW-1:0] x);
        logic [31:0] w;
        w = 32'(x);
        return w[4:0];
    endfunction

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_commit   = (r_state == S_DONE) && w_out_free;
    assign w_full     = r_fill >= CW'(DEPTH);

    assign w_cmd.add_en = w_commit && (r_op == bmt_pkg::OP_ADD) && !w_full;
    assign w_cmd.rm_en  = w_commit && (r_op == bmt_pkg::OP_REMOVE) && r_have;

    // Token enters cell 0 the cycle after acceptance, once r_val is loaded
    assign w_tok[0]  = r_start;
    assign w_cnt[0]  = '0;
    assign w_have[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_next;
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end
        bmt_cell #(
            .IDX         (g),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CW          (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_val   (r_val),
            .i_fill  (r_fill),
            .i_cmd   (w_cmd),
            .i_next  (w_next),
            .i_tok   (w_tok[g]),
            .i_cnt   (w_cnt[g]),
            .i_have  (w_have[g]),
            .o_tok   (w_tok[g+1]),
            .o_cnt   (w_cnt[g+1]),
            .o_have  (w_have[g+1]),
            .o_entry (w_entry[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (w_tok[DEPTH]) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_fill = r_fill;
        w_ok   = 1'b1;
        unique case (r_op)
            bmt_pkg::OP_ADD: begin
                w_ok = !w_full;
                if (!w_full) n_fill = r_fill + CW'(1);
            end
            bmt_pkg::OP_REMOVE: begin
                w_ok = r_have;
                if (r_have) n_fill = r_fill - CW'(1);
            end
            bmt_pkg::OP_CLEAR: n_fill = '0;
            bmt_pkg::OP_QUERY: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept;
            if (w_commit) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in.func;
            r_val <= VALUE_WIDTH'(i_in.value);
        end
        if (w_tok[DEPTH]) begin
            r_cnt  <= w_cnt[DEPTH];
            r_have <= w_have[DEPTH];
        end
        if (w_commit) begin
            r_out.ok          <= w_ok;
            r_out.match_count <= to_5(r_cnt);
            r_out.found       <= r_have;
            r_out.size        <= to_5(n_fill);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    logic [DEPTH:0] w_tok_vec;
    for (genvar g = 0; g <= DEPTH; g++) begin : g_tokv
        assign w_tok_vec[g] = w_tok[g];
    end

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vec))
        else $error("more than one scan token in the cell row");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_tok_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[DEPTH] |-> (r_state == S_SWEEP))
        else $error("scan token left the row outside a sweep");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.add_en |=> (r_fill == $past(r_fill) + CW'(1)))
        else $error("successful add did not grow the table");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_out_valid)
        else $error("commit without a result beat");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bounded multiset table
// A queue of operations feeds a clocked driver; a clocked monitor checks every
// result beat against a bag model updated as each input beat is taken.
// Both sides idle at random, with quiet stretches, and the receiver holds off
// for long stretches twice so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int BAG_DEPTH  = 16;
    localparam int MAX_IDLE   = 13;
    localparam int LONG_HOLD  = 300;
    localparam int RAND_OPS   = 1025;
    localparam int POOL_SIZE  = 8;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               in_valid   = 1'b0;
    bmt_pkg::t_bmt_in   in_beat    = '0;
    logic               out_stall  = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    bmt_pkg::t_bmt_out  o_out;

    bmt_pkg::t_bmt_in  pending_ops_q[$];
    bmt_pkg::t_bmt_out expected_reports_q[$];
    logic [31:0]       bag_model_q[$];
    logic [31:0]       value_pool[POOL_SIZE];

    int  ops_total    = 0;
    int  ops_taken    = 0;
    int  reports_seen = 0;
    int  err_cnt      = 0;
    int  in_gap       = 0;
    int  rx_hold      = 0;
    logic drv_busy;

    bounded_multiset_table #(
        .DEPTH       (BAG_DEPTH),
        .VALUE_WIDTH (32)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    always #2 i_clk = ~i_clk;

    // Applies one operation to the bag model and returns its report
    function automatic bmt_pkg::t_bmt_out bag_apply(input bmt_pkg::t_bmt_in op);
        bmt_pkg::t_bmt_out rpt;
        int                first_idx;
        int                hits;
        first_idx = -1;
        hits      = 0;
        foreach (bag_model_q[i]) begin
            if (bag_model_q[i] == op.value) begin
                if (first_idx < 0) first_idx = i;
                hits++;
            end
        end
        rpt.ok          = 1'b1;
        rpt.match_count = 5'(hits);
        rpt.found       = (hits != 0);
        case (op.func)
            bmt_pkg::OP_ADD: begin
                if (bag_model_q.size() < BAG_DEPTH)
                    bag_model_q.insert(bag_model_q.size(), op.value);
                else rpt.ok = 1'b0;
            end
            bmt_pkg::OP_REMOVE: begin
                if (first_idx >= 0) bag_model_q.delete(first_idx);
                else rpt.ok = 1'b0;
            end
            bmt_pkg::OP_CLEAR: begin
                bag_model_q.delete();
            end
            default: begin
            end
        endcase
        rpt.size = 5'(bag_model_q.size());
        return rpt;
    endfunction

    task automatic push_op(input logic [1:0] func, input logic [31:0] value);
        bmt_pkg::t_bmt_in op;
        op.func  = func;
        op.value = value;
        pending_ops_q.insert(pending_ops_q.size(), op);
    endtask

    // Mostly values from a small pool so that matches and duplicates are common
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Driver: one beat in flight, held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else begin
            drv_busy = in_valid && o_in_stall;
            if (in_valid && !o_in_stall) begin
                expected_reports_q.insert(expected_reports_q.size(), bag_apply(in_beat));
                ops_taken++;
            end
            if (drv_busy) begin
                // payload stays put
            end else if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end else if (pending_ops_q.size() != 0) begin
                in_beat  <= pending_ops_q.pop_front();
                in_valid <= 1'b1;
                // every fourth stretch of 40 beats runs back to back
                if (((ops_taken / 40) % 4) == 1) in_gap <= 0;
                else in_gap <= $urandom_range(0, MAX_IDLE);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat, then draws its own hold-off
    always @(posedge i_clk) begin
        bmt_pkg::t_bmt_out exp_rpt;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            rx_hold   = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_reports_q.size() == 0) begin
                    $error("result beat with nothing expected: %p", o_out);
                    err_cnt++;
                end else begin
                    exp_rpt = expected_reports_q.pop_front();
                    if (o_out.ok !== exp_rpt.ok) begin
                        $error("ok: expected %0d, got %0d", exp_rpt.ok, o_out.ok);
                        err_cnt++;
                    end
                    if (o_out.match_count !== exp_rpt.match_count) begin
                        $error("match_count: expected %0d, got %0d",
                               exp_rpt.match_count, o_out.match_count);
                        err_cnt++;
                    end
                    if (o_out.found !== exp_rpt.found) begin
                        $error("found: expected %0d, got %0d", exp_rpt.found, o_out.found);
                        err_cnt++;
                    end
                    if (o_out.size !== exp_rpt.size) begin
                        $error("size: expected %0d, got %0d", exp_rpt.size, o_out.size);
                        err_cnt++;
                    end
                end
                reports_seen++;
                if (reports_seen == 300 || reports_seen == 700) rx_hold = LONG_HOLD;
                else if (((reports_seen / 50) % 4) == 2) rx_hold = 0;
                else rx_hold = $urandom_range(0, MAX_IDLE);
            end else if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
            end
            out_stall <= (rx_hold > 0);
        end
    end

    initial begin
        int         r;
        int         add_pct;
        logic [1:0] func;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < POOL_SIZE; k++) value_pool[k] = $urandom;

        // Directed: empty table, duplicates, first-match removal, full, clear
        push_op(bmt_pkg::OP_QUERY,  32'h0000_0000);
        push_op(bmt_pkg::OP_REMOVE, 32'h0000_0000);
        push_op(bmt_pkg::OP_ADD,    32'h0000_0000);
        push_op(bmt_pkg::OP_ADD,    32'hFFFF_FFFF);
        push_op(bmt_pkg::OP_ADD,    32'hFFFF_FFFF);
        push_op(bmt_pkg::OP_QUERY,  32'hFFFF_FFFF);
        push_op(bmt_pkg::OP_REMOVE, 32'hFFFF_FFFF);
        push_op(bmt_pkg::OP_REMOVE, 32'h0000_0000);
        push_op(bmt_pkg::OP_REMOVE, 32'h1234_5678);
        for (int k = 0; k < BAG_DEPTH - 1; k++)
            push_op(bmt_pkg::OP_ADD, (k % 3 == 0) ? 32'hFFFF_FFFF : (32'hA5A5_0000 | k));
        push_op(bmt_pkg::OP_ADD,    32'h0000_0000);
        push_op(bmt_pkg::OP_CLEAR,  32'hFFFF_FFFF);
        push_op(bmt_pkg::OP_QUERY,  32'hFFFF_FFFF);

        // Random: alternate fill-heavy and drain-heavy phases
        for (int n = 0; n < RAND_OPS; n++) begin
            add_pct = ((n / 100) % 2 == 0) ? 55 : 25;
            r = $urandom_range(0, 99);
            if (r < 4)                func = bmt_pkg::OP_CLEAR;
            else if (r < 4 + add_pct) func = bmt_pkg::OP_ADD;
            else if (r < 84)          func = bmt_pkg::OP_REMOVE;
            else                      func = bmt_pkg::OP_QUERY;
            push_op(func, pick_value());
        end
        ops_total = pending_ops_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (ops_taken == ops_total);
        wait (expected_reports_q.size() == 0);
        repeat (2 * (BAG_DEPTH + 2)) @(posedge i_clk);
        if (err_cnt == 0 && expected_reports_q.size() == 0) begin
            $display("bounded_multiset_table: match");
        end else begin
            $display("bounded_multiset_table: mismatch");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("bounded_multiset_table: mismatch");
        $finish;
    end

endmodule

### filelist.f
src/bmt_pkg.sv
src/bmt_cell.sv
src/bounded_multiset_table.sv
tb/sv/tb_top.sv
